// File: rtl/coap_message_parser_top_assert.svh
// Assertion macros for the CoAP message parser top level.
`ifndef COAP_MESSAGE_PARSER_TOP_ASSERT_SVH
`define COAP_MESSAGE_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define COAP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("coap parser: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define COAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("coap parser: next-cycle check failed");

`endif

// File: rtl/coap_mp_pkg.sv
// Types and constants shared by the CoAP message parser.
`default_nettype none

package coap_mp_pkg;

   localparam logic [7:0]  OPTION_LIMIT_RESET = 8'd16;
   localparam logic [7:0]  PAYLOAD_MARKER     = 8'hFF;
   localparam logic [1:0]  PROTOCOL_VERSION   = 2'd1;
   localparam logic [3:0]  MAX_TOKEN_LENGTH   = 4'd8;
   localparam logic [3:0]  NIBBLE_EXT8        = 4'd13;
   localparam logic [3:0]  NIBBLE_EXT16       = 4'd14;
   localparam logic [3:0]  NIBBLE_RESERVED    = 4'd15;
   localparam logic [15:0] EXT8_BIAS          = 16'd13;
   localparam logic [15:0] EXT16_BIAS         = 16'd269;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_TOKEN   = 3'd1,
      PH_OPTION  = 3'd2,
      PH_VALUE   = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_IGNORE  = 3'd5,
      PH_ERROR   = 3'd6
   } phase_type;

   // Position within an option header.
   typedef enum logic [2:0] {
      HS_NIBBLES   = 3'd0,
      HS_DELTA8    = 3'd1,
      HS_DELTA16_H = 3'd2,
      HS_DELTA16_L = 3'd3,
      HS_LEN8      = 3'd4,
      HS_LEN16_H   = 3'd5,
      HS_LEN16_L   = 3'd6
   } hstep_type;

   typedef enum logic [2:0] {
      CLS_HEADER  = 3'd0,
      CLS_TOKEN   = 3'd1,
      CLS_VALUE   = 3'd2,
      CLS_PAYLOAD = 3'd3,
      CLS_IGNORED = 3'd4
   } class_type;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_SHORT_HEADER   = 3'd1,
      ST_BAD_VERSION    = 3'd2,
      ST_TOKEN_ERROR    = 3'd3,
      ST_OPT_HDR_SHORT  = 3'd4,
      ST_DELTA_RESERVED = 3'd5,
      ST_LEN_RESERVED   = 3'd6,
      ST_OPT_OVERRUN    = 3'd7
   } status_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  byte_pos;
      logic [3:0]  token_left;
      hstep_type   hstep;
      logic [7:0]  ext_high;
      logic [15:0] option_number;
      logic [15:0] bytes_left;
      logic [7:0]  options_counted;
      logic [1:0]  message_type;
      logic [3:0]  token_length;
      logic [7:0]  code_value;
      logic [15:0] message_id;
      logic        version_bad;
      status_type  error_code;
      logic [3:0]  len_nibble;
      logic [15:0] cur_length;
      logic [7:0]  cur_index;
   } parse_state_type;

   typedef struct packed {
      class_type   byte_class;
      logic [7:0]  data_out;
      logic [15:0] option_number;
      logic [15:0] option_length;
      logic [7:0]  option_index;
      logic [1:0]  message_type;
      logic [3:0]  token_length;
      logic [7:0]  code_value;
      logic [15:0] message_id;
      logic [7:0]  options_found;
      logic        message_end;
      status_type  status;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/coap_message_parser_top.sv
// CoAP message parser: byte-serial header, token, option and payload decoder.
`default_nettype none
//
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_stall  data_byte, last_byte
//  rsp_      out        rsp_valid / rsp_stall  class, option and header fields, status
//  csr_      in         csr_write_enable       option limit (8 bit)
//
//  One request per cycle while req_stall is low, one response per request; the response
//  is registered in the response register, or in the skid entry while that register is held.
//  Parse state advances in the cycle of the request; the response is registered.
//  A one-entry skid buffer behind the response register keeps requests flowing
//  while a response is held; req_stall rises only once the skid entry is full.
//  Synchronous active-high reset: parser at message start, option limit = 16.
//  After the last byte of a message, parse state returns to its reset value.

module coap_message_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_byte_class,
   output logic [7:0]       rsp_data_out,
   output logic [15:0]      rsp_option_number,
   output logic [15:0]      rsp_option_length,
   output logic [7:0]       rsp_option_index,
   output logic [1:0]       rsp_message_type,
   output logic [3:0]       rsp_token_length,
   output logic [7:0]       rsp_code_value,
   output logic [15:0]      rsp_message_id,
   output logic [7:0]       rsp_options_found,
   output logic             rsp_message_end,
   output logic [2:0]       rsp_status,
   // configuration
   input  wire logic        csr_write_enable,
   input  wire logic [7:0]  csr_write_data
);

   localparam coap_mp_pkg::parse_state_type STATE_RESET = '{
      phase:           coap_mp_pkg::PH_HEADER,
      byte_pos:        2'd0,
      token_left:      4'd0,
      hstep:           coap_mp_pkg::HS_NIBBLES,
      ext_high:        8'd0,
      option_number:   16'd0,
      bytes_left:      16'd0,
      options_counted: 8'd0,
      message_type:    2'd0,
      token_length:    4'd0,
      code_value:      8'd0,
      message_id:      16'd0,
      version_bad:     1'b0,
      error_code:      coap_mp_pkg::ST_OK,
      len_nibble:      4'd0,
      cur_length:      16'd0,
      cur_index:       8'd0
   };

   coap_mp_pkg::parse_state_type state_ff, state_in, nxt;
   coap_mp_pkg::result_type      result;
   coap_mp_pkg::result_type      rsp_data_ff, rsp_data_in;
   coap_mp_pkg::result_type      skid_data_ff, skid_data_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         skid_valid_ff, skid_valid_in;
   logic [7:0]                   option_limit_ff, option_limit_in;

   logic                         req_accept;
   logic                         rsp_free;

   // decode scratch
   coap_mp_pkg::class_type       cls;
   coap_mp_pkg::status_type      err_code;
   logic                         err_req;
   logic                         do_delta;
   logic                         do_length;
   logic [15:0]                  delta_val;
   logic [15:0]                  length_val;
   logic [3:0]                   nib_delta;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------
   // Parse step: one byte through the framing state machine.
   // ------------------------------------------------------------------
   always_comb begin
      nxt        = state_ff;
      cls        = coap_mp_pkg::CLS_HEADER;
      err_req    = 1'b0;
      err_code   = coap_mp_pkg::ST_OK;
      do_delta   = 1'b0;
      do_length  = 1'b0;
      delta_val  = 16'd0;
      length_val = 16'd0;
      nib_delta  = req_data_byte[7:4];

      unique case (state_ff.phase)
         coap_mp_pkg::PH_HEADER: begin
            unique case (state_ff.byte_pos)
               2'd0: begin
                  nxt.version_bad  = (req_data_byte[7:6] != coap_mp_pkg::PROTOCOL_VERSION);
                  nxt.message_type = req_data_byte[5:4];
                  nxt.token_length = req_data_byte[3:0];
               end
               2'd1: nxt.code_value = req_data_byte;
               2'd2: nxt.message_id[15:8] = req_data_byte;
               default: nxt.message_id[7:0] = req_data_byte;
            endcase
            if (state_ff.byte_pos != 2'd3) begin
               nxt.byte_pos = state_ff.byte_pos + 2'd1;
               if (req_last_byte) begin
                  err_req  = 1'b1;
                  err_code = coap_mp_pkg::ST_SHORT_HEADER;
               end
            end else if (nxt.version_bad) begin
               err_req  = 1'b1;
               err_code = coap_mp_pkg::ST_BAD_VERSION;
            end else if (nxt.token_length > coap_mp_pkg::MAX_TOKEN_LENGTH) begin
               err_req  = 1'b1;
               err_code = coap_mp_pkg::ST_TOKEN_ERROR;
            end else if (nxt.token_length == 4'd0) begin
               nxt.phase = coap_mp_pkg::PH_OPTION;
               nxt.hstep = coap_mp_pkg::HS_NIBBLES;
            end else begin
               nxt.token_left = nxt.token_length;
               nxt.phase      = coap_mp_pkg::PH_TOKEN;
               if (req_last_byte) begin
                  err_req  = 1'b1;
                  err_code = coap_mp_pkg::ST_TOKEN_ERROR;
               end
            end
         end

         coap_mp_pkg::PH_TOKEN: begin
            cls = coap_mp_pkg::CLS_TOKEN;
            if (state_ff.token_left != 4'd0) begin
               nxt.token_left = state_ff.token_left - 4'd1;
            end
            if (nxt.token_left == 4'd0) begin
               nxt.phase = coap_mp_pkg::PH_OPTION;
               nxt.hstep = coap_mp_pkg::HS_NIBBLES;
            end else if (req_last_byte) begin
               err_req  = 1'b1;
               err_code = coap_mp_pkg::ST_TOKEN_ERROR;
            end
         end

         coap_mp_pkg::PH_OPTION: begin
            unique case (state_ff.hstep)
               coap_mp_pkg::HS_NIBBLES: begin
                  if (req_data_byte == coap_mp_pkg::PAYLOAD_MARKER) begin
                     nxt.phase = coap_mp_pkg::PH_PAYLOAD;
                  end else if (state_ff.options_counted >= option_limit_ff) begin
                     // limit reached: drop the rest of the message silently
                     cls       = coap_mp_pkg::CLS_IGNORED;
                     nxt.phase = coap_mp_pkg::PH_IGNORE;
                  end else begin
                     nxt.cur_index  = state_ff.options_counted;
                     nxt.cur_length = 16'd0;
                     nxt.len_nibble = req_data_byte[3:0];
                     if (nib_delta == coap_mp_pkg::NIBBLE_RESERVED) begin
                        err_req  = 1'b1;
                        err_code = coap_mp_pkg::ST_DELTA_RESERVED;
                     end else if (nib_delta < coap_mp_pkg::NIBBLE_EXT8) begin
                        do_delta  = 1'b1;
                        delta_val = {12'd0, nib_delta};
                     end else begin
                        nxt.hstep = (nib_delta == coap_mp_pkg::NIBBLE_EXT8) ?
                                    coap_mp_pkg::HS_DELTA8 : coap_mp_pkg::HS_DELTA16_H;
                        if (req_last_byte) begin
                           err_req  = 1'b1;
                           err_code = coap_mp_pkg::ST_OPT_HDR_SHORT;
                        end
                     end
                  end
               end
               coap_mp_pkg::HS_DELTA8: begin
                  do_delta  = 1'b1;
                  delta_val = {8'd0, req_data_byte} + coap_mp_pkg::EXT8_BIAS;
               end
               coap_mp_pkg::HS_DELTA16_H: begin
                  nxt.ext_high = req_data_byte;
                  nxt.hstep    = coap_mp_pkg::HS_DELTA16_L;
                  if (req_last_byte) begin
                     err_req  = 1'b1;
                     err_code = coap_mp_pkg::ST_OPT_HDR_SHORT;
                  end
               end
               coap_mp_pkg::HS_DELTA16_L: begin
                  do_delta  = 1'b1;
                  delta_val = {state_ff.ext_high, req_data_byte} + coap_mp_pkg::EXT16_BIAS;
               end
               coap_mp_pkg::HS_LEN8: begin
                  do_length  = 1'b1;
                  length_val = {8'd0, req_data_byte} + coap_mp_pkg::EXT8_BIAS;
               end
               coap_mp_pkg::HS_LEN16_H: begin
                  nxt.ext_high = req_data_byte;
                  nxt.hstep    = coap_mp_pkg::HS_LEN16_L;
                  if (req_last_byte) begin
                     err_req  = 1'b1;
                     err_code = coap_mp_pkg::ST_OPT_HDR_SHORT;
                  end
               end
               default: begin
                  do_length  = 1'b1;
                  length_val = {state_ff.ext_high, req_data_byte} + coap_mp_pkg::EXT16_BIAS;
               end
            endcase
         end

         coap_mp_pkg::PH_VALUE: begin
            cls = coap_mp_pkg::CLS_VALUE;
            if (state_ff.bytes_left != 16'd0) begin
               nxt.bytes_left = state_ff.bytes_left - 16'd1;
            end
            if (nxt.bytes_left == 16'd0) begin
               nxt.options_counted = state_ff.options_counted + 8'd1;
               nxt.phase           = coap_mp_pkg::PH_OPTION;
               nxt.hstep           = coap_mp_pkg::HS_NIBBLES;
            end else if (req_last_byte) begin
               err_req  = 1'b1;
               err_code = coap_mp_pkg::ST_OPT_OVERRUN;
            end
         end

         coap_mp_pkg::PH_PAYLOAD: cls = coap_mp_pkg::CLS_PAYLOAD;

         default: cls = coap_mp_pkg::CLS_IGNORED;
      endcase

      // Delta complete: advance the running number, then look at the length nibble.
      if (do_delta) begin
         nxt.option_number = state_ff.option_number + delta_val;
         if (nxt.len_nibble == coap_mp_pkg::NIBBLE_RESERVED) begin
            err_req  = 1'b1;
            err_code = coap_mp_pkg::ST_LEN_RESERVED;
         end else if (nxt.len_nibble < coap_mp_pkg::NIBBLE_EXT8) begin
            do_length  = 1'b1;
            length_val = {12'd0, nxt.len_nibble};
         end else begin
            nxt.hstep = (nxt.len_nibble == coap_mp_pkg::NIBBLE_EXT8) ?
                        coap_mp_pkg::HS_LEN8 : coap_mp_pkg::HS_LEN16_H;
            if (req_last_byte) begin
               err_req  = 1'b1;
               err_code = coap_mp_pkg::ST_OPT_HDR_SHORT;
            end
         end
      end

      // Length complete: an empty option finishes here, otherwise expect its value.
      if (do_length) begin
         nxt.cur_length = length_val;
         nxt.hstep      = coap_mp_pkg::HS_NIBBLES;
         if (length_val == 16'd0) begin
            nxt.options_counted = state_ff.options_counted + 8'd1;
            nxt.phase           = coap_mp_pkg::PH_OPTION;
         end else begin
            nxt.bytes_left = length_val;
            nxt.phase      = coap_mp_pkg::PH_VALUE;
            if (req_last_byte) begin
               err_req  = 1'b1;
               err_code = coap_mp_pkg::ST_OPT_OVERRUN;
            end
         end
      end

      // Keep the first error; every later byte is ignored.
      if (err_req) begin
         if (state_ff.error_code == coap_mp_pkg::ST_OK) begin
            nxt.error_code = err_code;
         end
         nxt.phase = coap_mp_pkg::PH_ERROR;
      end

      result.byte_class    = cls;
      result.data_out      = req_data_byte;
      result.option_number = nxt.option_number;
      result.option_length = nxt.cur_length;
      result.option_index  = nxt.cur_index;
      result.message_type  = nxt.message_type;
      result.token_length  = nxt.token_length;
      result.code_value    = nxt.code_value;
      result.message_id    = nxt.message_id;
      result.options_found = nxt.options_counted;
      result.message_end   = req_last_byte;
      result.status        = nxt.error_code;

      // Advance only on an accepted request; restart after the last byte.
      state_in = state_ff;
      if (req_accept) begin
         state_in = req_last_byte ? STATE_RESET : nxt;
      end
   end

   // ------------------------------------------------------------------
   // Response register with one-entry skid buffer.
   // ------------------------------------------------------------------
   always_comb begin
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_data_in   = skid_data_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (req_accept) begin
            rsp_data_in  = result;
            rsp_valid_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         // response held: park this one in the skid entry
         skid_data_in  = result;
         skid_valid_in = 1'b1;
      end
   end

   assign option_limit_in = csr_write_enable ? csr_write_data : option_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= STATE_RESET;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
         option_limit_ff <= coap_mp_pkg::OPTION_LIMIT_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         skid_valid_ff   <= skid_valid_in;
         option_limit_ff <= option_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_byte_class    = rsp_data_ff.byte_class;
   assign rsp_data_out      = rsp_data_ff.data_out;
   assign rsp_option_number = rsp_data_ff.option_number;
   assign rsp_option_length = rsp_data_ff.option_length;
   assign rsp_option_index  = rsp_data_ff.option_index;
   assign rsp_message_type  = rsp_data_ff.message_type;
   assign rsp_token_length  = rsp_data_ff.token_length;
   assign rsp_code_value    = rsp_data_ff.code_value;
   assign rsp_message_id    = rsp_data_ff.message_id;
   assign rsp_options_found = rsp_data_ff.options_found;
   assign rsp_message_end   = rsp_data_ff.message_end;
   assign rsp_status        = rsp_data_ff.status;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`include "coap_message_parser_top_assert.svh"

   // the skid entry only fills behind a held response
   `COAP_ASSERT_NOW(a_skid_behind_rsp, clock, reset, skid_valid_ff, rsp_valid_ff)

   // a recorded error always parks the parser in the error phase
   `COAP_ASSERT_NOW(a_error_parks, clock, reset,
      state_ff.error_code != coap_mp_pkg::ST_OK, state_ff.phase == coap_mp_pkg::PH_ERROR)

   // the last byte of a message restarts parsing at the header
   `COAP_ASSERT_NEXT(a_last_restarts, clock, reset, req_accept && req_last_byte,
      state_ff.phase == coap_mp_pkg::PH_HEADER && state_ff.byte_pos == 2'd0 &&
      state_ff.options_counted == 8'd0)

endmodule

`default_nettype wire

// File: tb/sv/coap_decode_board_pkg.sv
// Scoreboard class: byte-level CoAP decode prediction and response checking.
`timescale 1ns / 1ps

package coap_decode_board_pkg;

   import coap_mp_pkg::*;

   class coap_decode_board;
      logic [7:0]  option_limit;
      phase_type   phase;
      int unsigned header_pos;
      logic [3:0]  token_left;
      hstep_type   hstep;
      logic [15:0] ext_high;
      logic [15:0] option_number;
      logic [15:0] value_left;
      logic [7:0]  options_done;
      logic [1:0]  message_type;
      logic [3:0]  token_length;
      logic [7:0]  code_value;
      logic [15:0] message_id;
      bit          version_bad;
      status_type  first_error;
      logic [3:0]  length_nibble;
      logic [15:0] option_length;
      logic [7:0]  option_index;
      result_type  decoded_due[$];
      int unsigned mismatch_count;

      function new();
         option_limit = OPTION_LIMIT_RESET;
         mismatch_count = 0;
         start_message();
      endfunction

      function void start_message();
         phase = PH_HEADER;
         header_pos = 0;
         token_left = '0;
         hstep = HS_NIBBLES;
         ext_high = '0;
         option_number = '0;
         value_left = '0;
         options_done = '0;
         message_type = '0;
         token_length = '0;
         code_value = '0;
         message_id = '0;
         version_bad = 1'b0;
         first_error = ST_OK;
         length_nibble = '0;
         option_length = '0;
         option_index = '0;
      endfunction

      // Keep the first error; every later byte of the message is ignored.
      function void raise_status(status_type code);
         if (first_error == ST_OK)
            first_error = code;
         phase = PH_ERROR;
      endfunction

      function void take_length(logic [15:0] len, bit last);
         option_length = len;
         hstep = HS_NIBBLES;
         if (len == 16'd0) begin
            options_done = options_done + 8'd1;
            phase = PH_OPTION;
         end else begin
            value_left = len;
            phase = PH_VALUE;
            if (last)
               raise_status(ST_OPT_OVERRUN);
         end
      endfunction

      function void take_delta(logic [15:0] delta, bit last);
         option_number = option_number + delta;
         if (length_nibble == NIBBLE_RESERVED)
            raise_status(ST_LEN_RESERVED);
         else if (length_nibble < NIBBLE_EXT8)
            take_length({12'd0, length_nibble}, last);
         else begin
            hstep = (length_nibble == NIBBLE_EXT8) ? HS_LEN8 : HS_LEN16_H;
            if (last)
               raise_status(ST_OPT_HDR_SHORT);
         end
      endfunction

      function void predict_byte(logic [7:0] b, bit last);
         class_type  cls;
         result_type r;
         cls = CLS_HEADER;
         case (phase)
            PH_HEADER: begin
               case (header_pos)
                  0: begin
                     version_bad = (b[7:6] != PROTOCOL_VERSION);
                     message_type = b[5:4];
                     token_length = b[3:0];
                  end
                  1: code_value = b;
                  2: message_id[15:8] = b;
                  default: message_id[7:0] = b;
               endcase
               if (header_pos < 3) begin
                  header_pos++;
                  if (last)
                     raise_status(ST_SHORT_HEADER);
               end else if (version_bad)
                  raise_status(ST_BAD_VERSION);
               else if (token_length > MAX_TOKEN_LENGTH)
                  raise_status(ST_TOKEN_ERROR);
               else if (token_length == 4'd0) begin
                  phase = PH_OPTION;
                  hstep = HS_NIBBLES;
               end else begin
                  token_left = token_length;
                  phase = PH_TOKEN;
                  if (last)
                     raise_status(ST_TOKEN_ERROR);
               end
            end
            PH_TOKEN: begin
               cls = CLS_TOKEN;
               if (token_left > 0)
                  token_left--;
               if (token_left == 0) begin
                  phase = PH_OPTION;
                  hstep = HS_NIBBLES;
               end else if (last)
                  raise_status(ST_TOKEN_ERROR);
            end
            PH_OPTION: begin
               case (hstep)
                  HS_NIBBLES: begin
                     if (b == PAYLOAD_MARKER)
                        phase = PH_PAYLOAD;
                     else if (options_done >= option_limit) begin
                        cls = CLS_IGNORED;
                        phase = PH_IGNORE;
                     end else begin
                        option_index = options_done;
                        option_length = '0;
                        length_nibble = b[3:0];
                        if (b[7:4] == NIBBLE_RESERVED)
                           raise_status(ST_DELTA_RESERVED);
                        else if (b[7:4] < NIBBLE_EXT8)
                           take_delta({12'd0, b[7:4]}, last);
                        else begin
                           hstep = (b[7:4] == NIBBLE_EXT8) ? HS_DELTA8 : HS_DELTA16_H;
                           if (last)
                              raise_status(ST_OPT_HDR_SHORT);
                        end
                     end
                  end
                  HS_DELTA8: take_delta({8'd0, b} + EXT8_BIAS, last);
                  HS_DELTA16_H, HS_LEN16_H: begin
                     ext_high = {b, 8'd0};
                     hstep = (hstep == HS_DELTA16_H) ? HS_DELTA16_L : HS_LEN16_L;
                     if (last)
                        raise_status(ST_OPT_HDR_SHORT);
                  end
                  HS_DELTA16_L: take_delta((ext_high | {8'd0, b}) + EXT16_BIAS, last);
                  HS_LEN8: take_length({8'd0, b} + EXT8_BIAS, last);
                  default: take_length((ext_high | {8'd0, b}) + EXT16_BIAS, last);
               endcase
            end
            PH_VALUE: begin
               cls = CLS_VALUE;
               if (value_left > 0)
                  value_left--;
               if (value_left == 0) begin
                  options_done = options_done + 8'd1;
                  phase = PH_OPTION;
                  hstep = HS_NIBBLES;
               end else if (last)
                  raise_status(ST_OPT_OVERRUN);
            end
            PH_PAYLOAD: cls = CLS_PAYLOAD;
            default: cls = CLS_IGNORED;
         endcase

         r.byte_class = cls;
         r.data_out = b;
         r.option_number = option_number;
         r.option_length = option_length;
         r.option_index = option_index;
         r.message_type = message_type;
         r.token_length = token_length;
         r.code_value = code_value;
         r.message_id = message_id;
         r.options_found = options_done;
         r.message_end = last;
         r.status = first_error;
         decoded_due.push_back(r);
         if (last)
            start_message();
      endfunction

      function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
         if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
            mismatch_count++;
         end
      endfunction

      function void check_decoded(result_type got);
         result_type want;
         if (decoded_due.size() == 0) begin
            $display("%0t: response with nothing expected, expected none, actual data_out %0h",
                     $time, got.data_out);
            mismatch_count++;
            return;
         end
         want = decoded_due.pop_front();
         compare_field("byte_class", want.byte_class, got.byte_class);
         compare_field("data_out", want.data_out, got.data_out);
         compare_field("option_number", want.option_number, got.option_number);
         compare_field("option_length", want.option_length, got.option_length);
         compare_field("option_index", want.option_index, got.option_index);
         compare_field("message_type", want.message_type, got.message_type);
         compare_field("token_length", want.token_length, got.token_length);
         compare_field("code_value", want.code_value, got.code_value);
         compare_field("message_id", want.message_id, got.message_id);
         compare_field("options_found", want.options_found, got.options_found);
         compare_field("message_end", want.message_end, got.message_end);
         compare_field("status", want.status, got.status);
      endfunction
   endclass

endpackage

// File: tb/sv/tb_top.sv
// Top-level testbench for the CoAP message parser: stimulus, pacing and checking.
`timescale 1ns / 1ps

module tb_top;

   import coap_mp_pkg::*;
   import coap_decode_board_pkg::*;

   localparam int unsigned ITEM_TARGET   = 1200;
   localparam int unsigned PHASE_ITEMS   = 150;
   localparam int unsigned DRAIN_LIMIT   = 4000;
   localparam int unsigned SETTLE_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_byte_class;
   logic [7:0]  rsp_data_out;
   logic [15:0] rsp_option_number;
   logic [15:0] rsp_option_length;
   logic [7:0]  rsp_option_index;
   logic [1:0]  rsp_message_type;
   logic [3:0]  rsp_token_length;
   logic [7:0]  rsp_code_value;
   logic [15:0] rsp_message_id;
   logic [7:0]  rsp_options_found;
   logic        rsp_message_end;
   logic [2:0]  rsp_status;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data = 8'd0;

   coap_decode_board board;
   logic [7:0]       msg[$];
   int unsigned      sent_items = 0;
   bit               req_eager = 1'b0;
   bit               rsp_eager = 1'b0;

   always #5 clock = ~clock;

   coap_message_parser_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_byte_class    (rsp_byte_class),
      .rsp_data_out      (rsp_data_out),
      .rsp_option_number (rsp_option_number),
      .rsp_option_length (rsp_option_length),
      .rsp_option_index  (rsp_option_index),
      .rsp_message_type  (rsp_message_type),
      .rsp_token_length  (rsp_token_length),
      .rsp_code_value    (rsp_code_value),
      .rsp_message_id    (rsp_message_id),
      .rsp_options_found (rsp_options_found),
      .rsp_message_end   (rsp_message_end),
      .rsp_status        (rsp_status),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   // Present one request and hold it until it is taken. Inputs only change at
   // rising edges; stall is sampled at the falling edge, where it is settled, so
   // the sample tells whether the coming edge accepts the request.
   task automatic send_byte(logic [7:0] b, bit last);
      int  gap;
      bit  taken;
      gap = req_eager ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do begin
         @(negedge clock);
         taken = !req_stall;
         // Predict now: the request is certain to go in at the next edge.
         if (taken)
            board.predict_byte(b, last);
         @(posedge clock);
      end while (!taken);
   endtask

   // Send the composed message, flagging its final byte.
   task automatic send_message();
      foreach (msg[i])
         send_byte(msg[i], i == msg.size() - 1);
      sent_items += msg.size();
   endtask

   // Drop valid and hold off until every predicted response has been checked.
   // The loop waits on the clock before its first check, so that valid is never lowered and raised in one step.
   task automatic wait_drained();
      int unsigned guard;
      guard = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         guard++;
      end while (board.decoded_due.size() != 0 && guard < DRAIN_LIMIT);
   endtask

   // Write the option limit while the parser is idle; one response per request
   // means an empty expectation queue leaves nothing in flight.
   task automatic write_option_limit(logic [7:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.option_limit = value;
   endtask

   // Build one message: mostly well-formed framing with random content, some
   // with a broken header, reserved nibbles or a cut-off tail, and a little noise.
   task automatic compose_message();
      int          roll;
      int          n;
      int          v;
      int          vlen;
      logic [1:0]  ver;
      logic [3:0]  tkl;
      logic [3:0]  d_nib;
      logic [3:0]  l_nib;
      logic [15:0] d_ext;
      logic [15:0] l_ext;
      bit          stop;
      msg.delete();
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         n = $urandom_range(1, 8);
         repeat (n) msg.push_back(8'($urandom));
         return;
      end

      ver = PROTOCOL_VERSION;
      tkl = 4'($urandom_range(0, 8));
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
         v = $urandom_range(0, 2);
         ver = (v == 0) ? 2'd0 : 2'(v + 1);
      end else if (roll == 1)
         tkl = 4'($urandom_range(9, 15));
      msg.push_back({ver, 2'($urandom), tkl});
      repeat (3) msg.push_back(8'($urandom));
      if (tkl <= MAX_TOKEN_LENGTH)
         repeat (tkl) msg.push_back(8'($urandom));

      // Mostly a handful of options; sometimes enough to run into the limit.
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
      stop = 1'b0;
      for (int i = 0; i < n && !stop; i++) begin
         d_ext = '0;
         l_ext = '0;
         roll = $urandom_range(0, 19);
         if (roll < 12)
            d_nib = 4'($urandom_range(0, 12));
         else if (roll < 16) begin
            d_nib = NIBBLE_EXT8;
            d_ext = 16'($urandom_range(0, 255));
         end else if (roll < 19) begin
            d_nib = NIBBLE_EXT16;
            d_ext = 16'($urandom);
         end else
            d_nib = NIBBLE_RESERVED;

         // Keep value lengths short: extended lengths use the low end of the
         // one-byte form, or the two-byte form wrapped round to a few bytes.
         roll = $urandom_range(0, 19);
         vlen = 0;
         if (roll < 14) begin
            l_nib = 4'($urandom_range(0, (roll < 10) ? 4 : 12));
            vlen = l_nib;
         end else if (roll < 17) begin
            l_nib = NIBBLE_EXT8;
            l_ext = 16'($urandom_range(0, 3));
            vlen = l_ext + EXT8_BIAS;
         end else if (roll < 19) begin
            l_nib = NIBBLE_EXT16;
            vlen = $urandom_range(0, 4);
            l_ext = 16'(vlen) - EXT16_BIAS;
         end else
            l_nib = NIBBLE_RESERVED;

         msg.push_back({d_nib, l_nib});
         if (d_nib == NIBBLE_EXT8)
            msg.push_back(d_ext[7:0]);
         else if (d_nib == NIBBLE_EXT16) begin
            msg.push_back(d_ext[15:8]);
            msg.push_back(d_ext[7:0]);
         end
         // A reserved nibble ends parsing; anything after it is ignored.
         stop = (d_nib == NIBBLE_RESERVED) || (l_nib == NIBBLE_RESERVED);
         if (!stop) begin
            if (l_nib == NIBBLE_EXT8)
               msg.push_back(l_ext[7:0]);
            else if (l_nib == NIBBLE_EXT16) begin
               msg.push_back(l_ext[15:8]);
               msg.push_back(l_ext[7:0]);
            end
            repeat (vlen) msg.push_back(8'($urandom));
         end
      end

      // Marker with zero or more payload bytes; a bare marker ends the message.
      if ($urandom_range(0, 3) != 0) begin
         msg.push_back(PAYLOAD_MARKER);
         repeat ($urandom_range(0, 6)) msg.push_back(8'($urandom));
      end

      // Cut the tail now and then: ends inside header, token, option, value or payload.
      if ($urandom_range(0, 6) == 0) begin
         n = $urandom_range(1, msg.size());
         while (msg.size() > n)
            void'(msg.pop_back());
      end
   endtask

   // Compare every response as it is taken; stall is stable at the falling edge.
   always @(negedge clock) begin
      result_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_byte_class, rsp_data_out, rsp_option_number, rsp_option_length,
                 rsp_option_index, rsp_message_type, rsp_token_length, rsp_code_value,
                 rsp_message_id, rsp_options_found, rsp_message_end, rsp_status};
         board.check_decoded(seen);
      end
   end

   // Response pacing: before each response draw a random stall length, and
   // flip now and then into a mode that never stalls.
   initial begin : rsp_pacer
      int hold;
      bit took;
      forever begin
         if ($urandom_range(0, 49) == 0)
            rsp_eager = !rsp_eager;
         hold = rsp_eager ? 0 : $urandom_range(0, 19);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do begin
            @(negedge clock);
            took = rsp_valid;
            @(posedge clock);
         end while (!took);
      end
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("coap_message_parser_top verification failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase_no;
      int unsigned phase_start;
      logic [7:0]  limit;
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed messages under the reset option limit of 16.
      // Short header outranks a bad version.
      msg = '{8'hC5, 8'h01};
      send_message();
      // Bad version with an otherwise all-ones header and a token length above 8.
      msg = '{8'hBF, 8'hFF, 8'hFF, 8'hFF};
      send_message();
      // Bad version, then a byte that is ignored.
      msg = '{8'h80, 8'h00, 8'h00, 8'h00, 8'h5A};
      send_message();
      // Token length of 8, message ends inside the token.
      msg = '{8'h48, 8'h00, 8'h00, 8'h00, 8'h11};
      send_message();
      // Two-byte delta wrapping to zero, one value byte, marker as last byte.
      msg = '{8'h40, 8'h00, 8'h00, 8'h00, 8'hE1, 8'hFE, 8'hF3, 8'h0A, PAYLOAD_MARKER};
      send_message();
      // Reserved delta nibble.
      msg = '{8'h60, 8'hFF, 8'h00, 8'hFF, 8'hF0};
      send_message();

      // Random phases, each under its own option limit. Start with both
      // extremes, then mostly small limits so that the limit is hit often.
      phase_no = 0;
      while (sent_items < ITEM_TARGET) begin
         case (phase_no)
            0: limit = 8'd1;
            1: limit = 8'd255;
            default: limit = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255))
                                                         : 8'($urandom_range(1, 6));
         endcase
         write_option_limit(limit);

         // At the top limit, run the option count all the way up and past it.
         if (phase_no == 1) begin
            msg = '{8'h40, 8'h01, 8'h00, 8'h01};
            repeat (258) msg.push_back({4'($urandom_range(0, 12)), 4'd0});
            msg.push_back(PAYLOAD_MARKER);
            send_message();
         end

         phase_start = sent_items;
         while (sent_items - phase_start < PHASE_ITEMS && sent_items < ITEM_TARGET) begin
            req_eager = ($urandom_range(0, 3) == 0);
            compose_message();
            send_message();
            // Hold off now and then until the parser has answered everything.
            if ($urandom_range(0, 11) == 0)
               wait_drained();
         end
         phase_no++;
      end

      // Drain, then wait out the settling period to catch stray responses.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.decoded_due.size() != 0) begin
         $display("%0t: responses outstanding, expected 0, actual %0d",
                  $time, board.decoded_due.size());
         board.mismatch_count++;
      end
      if (board.mismatch_count == 0)
         $display("coap_message_parser_top verification clean");
      else
         $display("coap_message_parser_top verification failed");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/coap_mp_pkg.sv
rtl/coap_message_parser_top.sv
tb/sv/coap_decode_board_pkg.sv
tb/sv/tb_top.sv
